[src/brf_pkg.sv]
// Shared types and constants for the bisection root finder.
package brf_pkg;

  // Q16.16 operand, Q32.32 square and threshold widths
  localparam int unsigned XW   = 32;
  localparam int unsigned SQW  = 63;   // |x|^2 with |x| <= 2^31, so up to 2^62
  localparam int unsigned CW   = 31;   // constant and tolerance registers
  localparam int unsigned CSW  = 47;   // c << 16
  localparam int unsigned THW  = 48;   // (c +/- tol) << 16
  localparam int unsigned LIMW = 8;

  typedef logic [1:0] status_t;
  localparam status_t STATUS_FOUND   = 2'd0;
  localparam status_t STATUS_NO_SIGN = 2'd1;
  localparam status_t STATUS_UNCONV  = 2'd2;

  // Configuration register indexes
  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_OFFSET_CONST    = 2'd0;
  localparam cfg_idx_t CFG_TOLERANCE       = 2'd1;
  localparam cfg_idx_t CFG_ITERATION_LIMIT = 2'd2;

  typedef struct packed {
    logic signed [XW-1:0] bound_low;
    logic signed [XW-1:0] bound_high;
  } in_word_t;

  typedef struct packed {
    logic signed [XW-1:0] root_estimate;
    status_t              status;
    logic [LIMW-1:0]      steps_used;
  } out_word_t;

  // Sign of f and tolerance test, from the compare unit
  typedef struct packed {
    logic f_pos;
    logic f_neg;
    logic in_tol;
  } cmp_res_t;

endpackage

[src/brf_square.sv]
// Shared squaring unit: registered |x|^2 of a signed Q16.16 value.
module brf_square (
  input  logic                         clk,
  input  logic signed [brf_pkg::XW-1:0] x,
  output logic [brf_pkg::SQW-1:0]      sq_r
);
  import brf_pkg::*;

  logic [XW-1:0]   mag;
  logic [2*XW-1:0] prod;

  // magnitude; the most negative value maps onto 2^31 as wanted
  assign mag  = x[XW-1] ? (~x + 1'b1) : x;
  assign prod = mag * mag;

  always_ff @(posedge clk) begin
    sq_r <= prod[SQW-1:0];
  end

endmodule

[src/brf_cmp.sv]
// Compare unit: sign of f = x^2 - c and the tolerance window, from the square.
module brf_cmp (
  input  logic [brf_pkg::SQW-1:0] sq,
  input  logic [brf_pkg::CSW-1:0] c_shift,
  input  logic [brf_pkg::THW-1:0] tol_low,
  input  logic [brf_pkg::THW-1:0] tol_high,
  output brf_pkg::cmp_res_t       res
);
  import brf_pkg::*;

  logic [SQW-1:0] c_ext;
  logic [SQW-1:0] lo_ext;
  logic [SQW-1:0] hi_ext;

  assign c_ext  = {{(SQW-CSW){1'b0}}, c_shift};
  assign lo_ext = {{(SQW-THW){1'b0}}, tol_low};
  assign hi_ext = {{(SQW-THW){1'b0}}, tol_high};

  // |f| <= tol  <=>  c - tol <= x^2 <= c + tol
  assign res.f_pos  = sq > c_ext;
  assign res.f_neg  = sq < c_ext;
  assign res.in_tol = (sq >= lo_ext) && (sq <= hi_ext);

endmodule

[src/bisection_root_finder.sv]
// Bisection root finder for f(x) = x*x - c: sequencer, registers and ports.
// From input accept to out_valid a word goes through n bisection steps, n = steps
// taken (0 when there is no sign change or the limit is zero), n <= 255.
// The input stalls until the result is loaded; each step is one pass through the
// shared squarer and one compare/update state. Synchronous active-low reset clears
// the sequencer and output valid, and loads c = 5.0, tolerance = 7, limit = 100.
module bisection_root_finder #(
  parameter int unsigned MAX_STEPS = 255
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  brf_pkg::in_word_t            in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output brf_pkg::out_word_t           out_data,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  brf_pkg::cfg_idx_t            cfg_index,
  input  logic [31:0]                  cfg_data
);
  import brf_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_SQ_LO, S_SQ_HI, S_CHECK, S_SQ_MID, S_UPDATE, S_FINISH
  } state_t;

  state_t           state_r;
  logic [CW-1:0]    offset_const_r;
  logic [CW-1:0]    tolerance_r;
  logic [LIMW-1:0]  iteration_limit_r;

  logic signed [XW-1:0] lo_r, hi_r, mid_r;
  logic [CSW-1:0]   c_shift_r;
  logic [THW-1:0]   tol_low_r, tol_high_r;
  logic [LIMW-1:0]  limit_r, steps_r;
  logic             lo_pos_r, lo_zero_r;
  status_t          status_r;
  logic             out_valid_r;
  out_word_t        out_data_r;

  logic signed [XW-1:0] sq_x;
  logic [SQW-1:0]   sq_r;
  cmp_res_t         cmp;
  logic [CSW-1:0]   c_shift_nxt, tol_shift_nxt;
  logic [THW-1:0]   tol_high_nxt, tol_low_nxt;
  logic [LIMW-1:0]  limit_nxt, steps_nxt;
  logic             in_acc, out_free, differ, hi_zero;

  // floor((a + b) / 2) with the sum kept exact
  function automatic logic signed [XW-1:0] half_sum(input logic signed [XW-1:0] a,
                                                    input logic signed [XW-1:0] b);
    logic signed [XW:0] s;
    s = {a[XW-1], a} + {b[XW-1], b};
    return s[XW:1];
  endfunction

  assign in_acc    = in_valid && !in_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || !out_stall;

  // thresholds in Q32.32, formed once per word
  assign c_shift_nxt   = {offset_const_r, 16'd0};
  assign tol_shift_nxt = {tolerance_r, 16'd0};
  assign tol_high_nxt  = {1'b0, c_shift_nxt} + {1'b0, tol_shift_nxt};
  assign tol_low_nxt   = (tol_shift_nxt > c_shift_nxt) ? '0 :
                         {1'b0, c_shift_nxt - tol_shift_nxt};
  assign limit_nxt     = ({24'd0, iteration_limit_r} > 32'(MAX_STEPS)) ?
                         LIMW'(MAX_STEPS) : iteration_limit_r;

  // shared squarer operand select
  always_comb begin
    unique case (state_r)
      S_SQ_LO: sq_x = lo_r;
      S_SQ_HI: sq_x = hi_r;
      default: sq_x = mid_r;
    endcase
  end

  brf_square u_square (
    .clk  (clk),
    .x    (sq_x),
    .sq_r (sq_r)
  );

  brf_cmp u_cmp (
    .sq       (sq_r),
    .c_shift  (c_shift_r),
    .tol_low  (tol_low_r),
    .tol_high (tol_high_r),
    .res      (cmp)
  );

  assign hi_zero   = !cmp.f_pos && !cmp.f_neg;
  assign differ    = lo_pos_r ? cmp.f_neg : cmp.f_pos;
  assign steps_nxt = steps_r + 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_const_r    <= CW'(327680);
      tolerance_r       <= CW'(7);
      iteration_limit_r <= LIMW'(100);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_OFFSET_CONST:    offset_const_r    <= cfg_data[CW-1:0];
        CFG_TOLERANCE:       tolerance_r       <= cfg_data[CW-1:0];
        CFG_ITERATION_LIMIT: iteration_limit_r <= cfg_data[LIMW-1:0];
        default: ;
      endcase
    end
  end

  // sequencer and working registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // the finish state reloads the slot itself when it frees
      if (out_valid_r && !out_stall && state_r != S_FINISH) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            lo_r       <= in_data.bound_low;
            hi_r       <= in_data.bound_high;
            c_shift_r  <= c_shift_nxt;
            tol_low_r  <= tol_low_nxt;
            tol_high_r <= tol_high_nxt;
            limit_r    <= limit_nxt;
            state_r    <= S_SQ_LO;
          end
        end
        S_SQ_LO: state_r <= S_SQ_HI;
        S_SQ_HI: begin
          lo_pos_r  <= cmp.f_pos;
          lo_zero_r <= !cmp.f_pos && !cmp.f_neg;
          state_r   <= S_CHECK;
        end
        S_CHECK: begin
          steps_r <= '0;
          if (lo_zero_r || hi_zero || (lo_pos_r == cmp.f_pos)) begin
            mid_r    <= '0;
            status_r <= STATUS_NO_SIGN;
            state_r  <= S_FINISH;
          end else if (limit_r == '0) begin
            mid_r    <= '0;
            status_r <= STATUS_UNCONV;
            state_r  <= S_FINISH;
          end else begin
            mid_r   <= half_sum(lo_r, hi_r);
            state_r <= S_SQ_MID;
          end
        end
        S_SQ_MID: state_r <= S_UPDATE;
        S_UPDATE: begin
          steps_r <= steps_nxt;
          if (cmp.in_tol) begin
            status_r <= STATUS_FOUND;
            state_r  <= S_FINISH;
          end else if (steps_nxt == limit_r) begin
            status_r <= STATUS_UNCONV;
            state_r  <= S_FINISH;
          end else begin
            // keep the half whose ends straddle the sign change
            if (differ) begin
              hi_r  <= mid_r;
              mid_r <= half_sum(lo_r, mid_r);
            end else begin
              lo_r     <= mid_r;
              lo_pos_r <= cmp.f_pos;
              mid_r    <= half_sum(mid_r, hi_r);
            end
            state_r <= S_SQ_MID;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (state_r == S_FINISH && out_free) begin
      out_data_r.root_estimate <= mid_r;
      out_data_r.status        <= status_r;
      out_data_r.steps_used    <= steps_r;
    end
  end

  // a bisection step never runs past the limit
  a_step_limit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_UPDATE |-> steps_r < limit_r)
    else $error("bisection step beyond limit");

  // a word taken in keeps the input stalled on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> in_stall)
    else $error("input not stalled after accept");

  // no sign change reports zero estimate and zero steps
  a_no_sign_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == STATUS_NO_SIGN |->
      out_data.steps_used == '0 && out_data.root_estimate == '0)
    else $error("no-sign-change result not zeroed");

  // the finish state loads the result only into a free slot
  a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FINISH && out_valid_r && out_stall |=> state_r == S_FINISH)
    else $error("result dropped while output stalled");

endmodule

[verif/testbench.sv]
// Self-checking testbench for the bisection root finder: driver, monitor and root predictor.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import brf_pkg::*;

  localparam int unsigned STEP_CAP    = 255;
  localparam int unsigned CYCLE_LIMIT = 4_000_000;
  localparam int          Q_ONE       = 65536;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam cfg_idx_t    CFG_UNMAPPED = 2'd3;

  logic        clk;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  in_word_t    in_data   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_word_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  cfg_idx_t    cfg_index = CFG_OFFSET_CONST;
  logic [31:0] cfg_data  = '0;

  // Register shadow, as last written
  logic [30:0] reg_offset = 31'd327680;
  logic [30:0] reg_tol    = 31'd7;
  logic [7:0]  reg_lim    = 8'd100;

  in_word_t    brackets_pending[$];
  out_word_t   expected_roots[$];
  out_word_t   want;
  logic        bracket_taken = 1'b0;
  int          in_gap = 0;
  int          out_hold_cycles = 0;
  logic        steady = 1'b0;
  int          mismatches = 0;
  int unsigned cycle_count = 0;

  bisection_root_finder #(.MAX_STEPS(STEP_CAP)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // f(x) = x*x - c in Q32.32
  function automatic longint residual(longint x);
    return x * x - (longint'(reg_offset) <<< 16);
  endfunction

  function automatic int polarity(longint v);
    if (v > 0) return 1;
    if (v < 0) return -1;
    return 0;
  endfunction

  // Expected word for one bracket under the current register values
  function automatic out_word_t solve_bracket(in_word_t w);
    longint      lo, hi, mid, f_lo, f_hi, f_mid, tol;
    int unsigned lim, n;
    out_word_t   r;
    lo   = w.bound_low;
    hi   = w.bound_high;
    f_lo = residual(lo);
    f_hi = residual(hi);
    tol  = longint'(reg_tol) <<< 16;
    lim  = (reg_lim > STEP_CAP) ? STEP_CAP : reg_lim;
    r.root_estimate = '0;
    r.status        = STATUS_NO_SIGN;
    r.steps_used    = '0;
    if (polarity(f_lo) * polarity(f_hi) >= 0) return r;
    r.status = STATUS_UNCONV;
    mid = 0;
    n   = 0;
    while (n < lim) begin
      mid   = (lo + hi) >>> 1;
      f_mid = residual(mid);
      if (polarity(f_lo) * polarity(f_mid) < 0) begin
        hi = mid;
      end else begin
        lo   = mid;
        f_lo = f_mid;
      end
      n++;
      if (f_mid <= tol && -f_mid <= tol) begin
        r.status = STATUS_FOUND;
        break;
      end
    end
    r.root_estimate = mid[31:0];
    r.steps_used    = n[7:0];
    return r;
  endfunction

  function automatic int draw_wait();
    return steady ? 0 : $urandom_range(0, 10);
  endfunction

  function automatic logic [31:0] extreme_value();
    case ($urandom_range(0, 4))
      0:       return Q_MIN;
      1:       return Q_MAX;
      2:       return '0;
      3:       return '1;
      default: return 32'h0001_0000;
    endcase
  endfunction

  task automatic send(input logic [31:0] lo, input logic [31:0] hi);
    in_word_t w;
    w.bound_low  = lo;
    w.bound_high = hi;
    brackets_pending.push_back(w);
  endtask

  // Wait until every bracket is taken and every word has come back
  task automatic drain();
    do @(posedge clk);
    while (brackets_pending.size() != 0 || in_valid || expected_roots.size() != 0);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk);
    while (!cfg_ready);
    case (idx)
      CFG_OFFSET_CONST:    reg_offset = val[30:0];
      CFG_TOLERANCE:       reg_tol    = val[30:0];
      CFG_ITERATION_LIMIT: reg_lim    = val[7:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Driver: present pending brackets, hold under stall, random gaps between words
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      expected_roots.push_back(solve_bracket(in_data));
      bracket_taken = 1'b1;
    end
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || bracket_taken) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (brackets_pending.size() != 0) begin
          in_data  <= brackets_pending.pop_front();
          in_valid <= 1'b1;
          in_gap = draw_wait();
        end else begin
          in_valid <= 1'b0;
        end
      end
      bracket_taken = 1'b0;
    end
  end

  // Monitor: check each accepted word against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      out_hold_cycles = draw_wait();
      if (expected_roots.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected word: root %0d status %0d steps %0d", $time,
                 out_data.root_estimate, out_data.status, out_data.steps_used);
      end else begin
        want = expected_roots.pop_front();
        if (out_data.root_estimate !== want.root_estimate) begin
          mismatches++;
          $display("%0t: root_estimate expected %0d got %0d", $time,
                   want.root_estimate, out_data.root_estimate);
        end
        if (out_data.status !== want.status) begin
          mismatches++;
          $display("%0t: status expected %0d got %0d", $time, want.status, out_data.status);
        end
        if (out_data.steps_used !== want.steps_used) begin
          mismatches++;
          $display("%0t: steps_used expected %0d got %0d", $time,
                   want.steps_used, out_data.steps_used);
        end
      end
    end
  end

  // Stall: hold each waiting word for its drawn count, toggle freely otherwise
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (out_valid) begin
      if (out_hold_cycles > 0) begin
        out_stall <= 1'b1;
        out_hold_cycles--;
      end else begin
        out_stall <= 1'b0;
      end
    end else begin
      out_stall <= steady ? 1'b0 : 1'($urandom_range(0, 1));
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("bisection_root_finder regression: fail");
      $finish;
    end
  end

  initial begin
    longint      root_q, inner, outer, span;
    int unsigned k, pick;
    logic [31:0] val;
    cfg_idx_t    idx;
    in_word_t    w;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset values: c = 5.0, root near 2.236
    send(0, 3 * Q_ONE);
    send(-3 * Q_ONE, 0);
    send(3 * Q_ONE, 0);            // reversed bracket
    send(0, 0);
    send(Q_MIN, Q_MAX);
    send(Q_MIN, 0);
    send(0, Q_MAX);
    send(-Q_ONE, Q_ONE);
    send(Q_MAX, Q_MIN);
    drain();

    // c = 4.0: root at an end, and exact zero at a midpoint
    write_reg(CFG_OFFSET_CONST, 32'h8004_0000);
    write_reg(CFG_TOLERANCE, 32'h0000_0000);
    write_reg(CFG_ITERATION_LIMIT, 32'h0000_0064);
    send(2 * Q_ONE, 5 * Q_ONE);
    send(-2 * Q_ONE, 0);
    send(0, 4 * Q_ONE);
    send(-4 * Q_ONE, 0);
    send(Q_ONE, 3 * Q_ONE);
    drain();

    // zero step limit
    write_reg(CFG_ITERATION_LIMIT, 32'hFFFF_FF00);
    send(0, 3 * Q_ONE);
    send(Q_MIN, 0);
    send(0, 0);
    drain();

    // largest constant, no tolerance, full step count
    write_reg(CFG_OFFSET_CONST, 32'hFFFF_FFFF);
    write_reg(CFG_ITERATION_LIMIT, 32'h0000_00FF);
    send(0, Q_MAX);
    send(Q_MIN, -Q_ONE);
    drain();

    // widest tolerance, tiny constant, write to an unmapped index
    write_reg(CFG_TOLERANCE, 32'hFFFF_FFFF);
    write_reg(CFG_OFFSET_CONST, 32'h0000_0001);
    write_reg(CFG_UNMAPPED, 32'h0000_0000);
    send(0, Q_ONE);
    send(Q_ONE, -Q_ONE);
    send(Q_MIN, 0);
    drain();

    // Random phases
    repeat (12) begin
      repeat ($urandom_range(2, 5)) begin
        idx = cfg_idx_t'($urandom_range(0, 3));
        val = $urandom();
        case (idx)
          CFG_OFFSET_CONST: begin
            case ($urandom_range(0, 4))
              0: val[30:0] = '0;
              1: val[30:0] = '1;
              2: begin
                k = $urandom_range(1, 46340);
                val[30:0] = 31'(k * k);
              end
              3: val[30:0] = 31'($urandom_range(1, 64 * Q_ONE));
              default: ;
            endcase
          end
          CFG_TOLERANCE: begin
            case ($urandom_range(0, 4))
              0: val[30:0] = '0;
              1: val[30:0] = '1;
              2: val[30:0] = 31'($urandom_range(0, 15));
              3: val[30:0] = 31'($urandom_range(0, 1 << 20));
              default: ;
            endcase
          end
          CFG_ITERATION_LIMIT: begin
            case ($urandom_range(0, 4))
              0: val[7:0] = '0;
              1: val[7:0] = 8'hFF;
              2: val[7:0] = 8'($urandom_range(1, 30));
              3: val[7:0] = 8'd100;
              default: ;
            endcase
          end
          default: ;
        endcase
        write_reg(idx, val);
      end
      steady = ($urandom_range(0, 3) == 0);

      root_q = longint'($sqrt(real'(reg_offset) * 65536.0));
      k = $rtoi($sqrt(real'(reg_offset)));
      repeat ($urandom_range(70, 110)) begin
        pick = $urandom_range(0, 9);
        if (pick < 7 && root_q >= 4) begin
          // one end inside the root, the other outside
          inner = longint'($urandom_range(0, 32'(root_q - 2)));
          span  = longint'(1) << $urandom_range(0, 30);
          outer = root_q + 2 + (longint'($urandom()) & (span - 1));
          if (outer > longint'(Q_MAX)) outer = longint'(Q_MAX);
          if ($urandom_range(0, 1)) inner = -inner;
          if ($urandom_range(0, 1)) outer = -outer;
          if (k * k == reg_offset && $urandom_range(0, 7) == 0)
            outer = ($urandom_range(0, 1) ? -256 : 256) * longint'(k);
          if ($urandom_range(0, 1)) begin
            w.bound_low  = inner[31:0];
            w.bound_high = outer[31:0];
          end else begin
            w.bound_low  = outer[31:0];
            w.bound_high = inner[31:0];
          end
        end else begin
          case (pick % 3)
            0: begin
              w.bound_low  = $urandom();
              w.bound_high = $urandom();
            end
            1: begin
              w.bound_low  = extreme_value();
              w.bound_high = extreme_value();
            end
            default: begin
              inner = longint'($urandom_range(0, 32'(root_q)));
              outer = longint'($urandom_range(0, 32'(root_q)));
              if ($urandom_range(0, 1)) inner = -inner;
              if ($urandom_range(0, 1)) outer = -outer;
              w.bound_low  = inner[31:0];
              w.bound_high = outer[31:0];
            end
          endcase
        end
        brackets_pending.push_back(w);
      end
      drain();
    end

    // let any stray word show up before the verdict
    repeat (2 * STEP_CAP + 16) @(posedge clk);
    if (mismatches == 0 && expected_roots.size() == 0) begin
      $display("bisection_root_finder regression: pass");
    end else begin
      $display("bisection_root_finder regression: fail");
    end
    $finish;
  end

endmodule

[bisection_root_finder.f]
src/brf_pkg.sv
src/brf_square.sv
src/brf_cmp.sv
src/bisection_root_finder.sv
verif/testbench.sv
